// ===== rtl/kex_pkg.sv =====
// Package: types and constants shared by the KEXINIT name-list extractor.
package kex_pkg;

    localparam int unsigned CODE_OFFSET  = 5;
    localparam int unsigned LISTS_OFFSET = 22;
    localparam int unsigned FIFO_DEPTH   = 4;
    localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [7:0]  SEMICOLON      = 8'h3B;
    localparam logic [7:0]  KEXINIT_RESET  = 8'd20;
    localparam logic [11:0] MIN_LEN_RESET  = 12'd300;
    localparam logic [11:0] MAX_LEN_RESET  = 12'd2000;

    localparam logic [2:0]  LIST_SECOND    = 3'd2;
    localparam logic [2:0]  LIST_FOURTH    = 3'd4;
    localparam logic [2:0]  LIST_SIXTH     = 3'd6;

    typedef enum logic [1:0] {
        REG_KEXINIT_CODE = 2'd0,
        REG_MIN_PAYLOAD  = 2'd1,
        REG_MAX_PAYLOAD  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [11:0] pkt_len;
        logic        byte_is_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       string_end;
        logic       truncated;
        logic       last_of_item;
    } out_beat_t;

    typedef struct packed {
        logic [1:0] count;
        out_beat_t  first;
        out_beat_t  second;
    } push_t;

endpackage

// ===== rtl/kex_parse.sv =====
// Input register, per-packet parse state and result generation.
module kex_parse #(
    parameter int unsigned OFFSET_BITS = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  kex_pkg::in_beat_t s_data,
    input  logic [7:0]        kexinit_code,
    input  logic [11:0]       min_payload,
    input  logic [11:0]       max_payload,
    input  logic              push_room,
    output kex_pkg::push_t    push
);
    import kex_pkg::*;

    logic                   in_vld_reg;
    in_beat_t               in_data_reg;
    logic                   advance;

    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [2:0]             list_reg, list_next;
    logic                   lenf_reg, lenf_next;
    logic [31:0]            acc_reg, acc_next;
    logic [31:0]            rem_reg, rem_next;
    logic                   sel_reg, sel_next;
    logic                   done_reg, done_next;

    logic                   main_v, main_e, trunc_v;
    logic [7:0]             main_c;
    logic [31:0]            rem_dec;
    out_beat_t              main_beat, trunc_beat;

    assign advance = in_vld_reg && push_room;
    assign s_ready = !in_vld_reg || push_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    assign rem_dec = rem_reg - 32'd1;

    always_comb begin
        offset_next = offset_reg;
        list_next   = list_reg;
        lenf_next   = lenf_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        sel_next    = sel_reg;
        done_next   = done_reg;
        main_v      = 1'b0;
        main_c      = in_data_reg.payload_byte;
        main_e      = 1'b0;
        trunc_v     = 1'b0;

        if (offset_reg == OFFSET_BITS'(CODE_OFFSET)) begin
            sel_next = (in_data_reg.pkt_len > min_payload) &&
                       (in_data_reg.pkt_len < max_payload) &&
                       (in_data_reg.payload_byte == kexinit_code);
        end else if (sel_reg && !done_reg && offset_reg >= OFFSET_BITS'(LISTS_OFFSET)) begin
            if (lenf_reg) begin
                acc_next = {acc_reg[23:0], in_data_reg.payload_byte};
                if (rem_reg >= 32'd3) begin
                    if (list_reg == LIST_SECOND || list_reg == LIST_FOURTH ||
                        list_reg == LIST_SIXTH) begin
                        main_v = 1'b1;
                        main_c = SEMICOLON;
                        main_e = (list_reg == LIST_SIXTH) && (acc_next == 32'd0);
                    end
                    if (acc_next == 32'd0) begin
                        list_next = list_reg + 3'd1;
                        lenf_next = 1'b1;
                        rem_next  = 32'd0;
                        done_next = (list_reg == LIST_SIXTH);
                    end else begin
                        lenf_next = 1'b0;
                        rem_next  = acc_next;
                    end
                    acc_next = 32'd0;
                end else begin
                    rem_next = rem_reg + 32'd1;
                end
            end else begin
                if (!list_reg[0]) begin
                    main_v = 1'b1;
                    main_e = (list_reg == LIST_SIXTH) && (rem_reg == 32'd1);
                end
                rem_next = rem_dec;
                if (rem_dec == 32'd0) begin
                    list_next = list_reg + 3'd1;
                    lenf_next = 1'b1;
                    acc_next  = 32'd0;
                    done_next = (list_reg == LIST_SIXTH);
                end
            end
        end

        if (offset_reg != {OFFSET_BITS{1'b1}}) begin
            offset_next = offset_reg + OFFSET_BITS'(1);
        end

        if (in_data_reg.byte_is_last) begin
            trunc_v     = sel_next && !done_next;
            offset_next = '0;
            list_next   = 3'd0;
            lenf_next   = 1'b1;
            acc_next    = 32'd0;
            rem_next    = 32'd0;
            sel_next    = 1'b0;
            done_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            list_reg   <= 3'd0;
            lenf_reg   <= 1'b1;
            acc_reg    <= 32'd0;
            rem_reg    <= 32'd0;
            sel_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end else if (advance) begin
            offset_reg <= offset_next;
            list_reg   <= list_next;
            lenf_reg   <= lenf_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            sel_reg    <= sel_next;
            done_reg   <= done_next;
        end
    end

    always_comb begin
        main_beat.out_char      = main_c;
        main_beat.string_end    = main_e;
        main_beat.truncated     = 1'b0;
        main_beat.last_of_item  = !trunc_v;
        trunc_beat.out_char     = 8'd0;
        trunc_beat.string_end   = 1'b0;
        trunc_beat.truncated    = 1'b1;
        trunc_beat.last_of_item = 1'b1;

        push.second = trunc_beat;
        if (main_v) begin
            push.first = main_beat;
        end else begin
            push.first = trunc_beat;
        end
        if (!advance) begin
            push.count = 2'd0;
        end else begin
            push.count = {1'b0, main_v} + {1'b0, trunc_v};
        end
    end

endmodule

// ===== rtl/kex_fifo.sv =====
// Result queue: takes up to two beats per cycle while it has room, hands out one while m_ready is high.
module kex_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  kex_pkg::push_t     push,
    output logic               push_room,
    output logic               m_valid,
    input  logic               m_ready,
    output kex_pkg::out_beat_t m_data
);
    import kex_pkg::*;

    out_beat_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_reg, wr_next;
    logic [FIFO_AW-1:0]   rd_reg, rd_next;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;
    logic                 pop;

    assign pop       = m_valid && m_ready;
    assign m_valid   = (cnt_reg != '0);
    assign m_data    = mem[rd_reg];
    assign push_room = (cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

    always_comb begin
        wr_next  = wr_reg + FIFO_AW'(push.count);
        rd_next  = rd_reg + FIFO_AW'(pop);
        cnt_next = cnt_reg + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_reg + FIFO_AW'(1)] <= push.second;
        end
    end

endmodule

// ===== rtl/ssh_kexinit_namelist_extract.sv =====
// Top level: SSH KEXINIT name-list extractor with configuration registers.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   payload_byte, pkt_len, byte_is_last
//  m_        out        m_valid / m_ready   out_char, string_end, truncated, last_of_item
//  cfg_      in         cfg_we              cfg_index, cfg_wdata
//
// One payload byte per cycle while s_ready is high: a beat is held in the input register,
// then its zero to two results enter a four-entry result queue.
// The first result becomes visible once the beat has passed the input register and been written into the queue.
// The result port drains one beat per cycle while m_ready is high, which bounds the rate when bytes yield two results.
// Synchronous active-low reset clears the parse state and restores register defaults.
// s_ready drops only while the queue holds more than two beats.
module ssh_kexinit_namelist_extract #(
    parameter int unsigned OFFSET_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  kex_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output kex_pkg::out_beat_t m_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_wdata
);
    import kex_pkg::*;

    logic [7:0]  code_reg;
    logic [11:0] min_reg;
    logic [11:0] max_reg;
    push_t       push;
    logic        push_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg <= KEXINIT_RESET;
            min_reg  <= MIN_LEN_RESET;
            max_reg  <= MAX_LEN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KEXINIT_CODE: code_reg <= cfg_wdata[7:0];
                REG_MIN_PAYLOAD:  min_reg  <= cfg_wdata;
                REG_MAX_PAYLOAD:  max_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    kex_parse #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .kexinit_code (code_reg),
        .min_payload  (min_reg),
        .max_payload  (max_reg),
        .push_room    (push_room),
        .push         (push)
    );

    kex_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_room (push_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
